// ===== src/pisp_pkg.sv =====
// ----------------------------------------------------------------------------
// pisp_pkg
// Shared types and codes of the palette import slot planner.
// ----------------------------------------------------------------------------
package pisp_pkg;

  localparam int COUNT_W  = 9;
  localparam int SLOT_W   = 8;
  localparam int TOTAL_W  = 8;
  localparam int STATUS_W = 3;
  localparam int MODE_W   = 2;
  localparam int COLOR_W  = 16;

  localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;

  localparam logic [MODE_W-1:0] MODE_BEGIN  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_LOAD   = 2'd1;
  localparam logic [MODE_W-1:0] MODE_IMPORT = 2'd2;

  localparam logic [STATUS_W-1:0] ST_DONE    = 3'd0;
  localparam logic [STATUS_W-1:0] ST_SKIP    = 3'd1;
  localparam logic [STATUS_W-1:0] ST_MATCH   = 3'd2;
  localparam logic [STATUS_W-1:0] ST_ADD     = 3'd3;
  localparam logic [STATUS_W-1:0] ST_NOROOM  = 3'd4;

  localparam logic CFG_DEST_COUNT = 1'b0;
  localparam logic CFG_DEST_CAP   = 1'b1;

  typedef struct packed {
    logic clr;
    logic wr_word;
    logic set_occ;
    logic wr_reus;
    logic reus_val;
  } cell_cmd_t;

endpackage

// ===== src/palette_import_slot_planner.sv =====
// ----------------------------------------------------------------------------
// palette_import_slot_planner
// Plans the merge of source palette colors into a destination palette table.
// ----------------------------------------------------------------------------
// Begin, load, skipped and unknown items pass from DISPATCH straight to FIN.
// An import that is not skipped sends a search token down the row of slot
// cells in the SCAN state, one slot per cycle from slot 1; a match ends the
// scan at that slot, a miss takes the next append slot, and when no append
// slot is left the hole pointer then walks one slot per cycle in HOLE. One
// item is in work at a time and the next transfer is taken in the cycle after
// a result is loaded into the output register; a result held by a low
// out_ready holds the next item too. Configuration writes are always taken.
module palette_import_slot_planner #(
  parameter int TABLE_ENTRIES = 256,
  parameter int WORD_BITS     = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic                              cfg_index,
  input  logic [pisp_pkg::COUNT_W-1:0]      cfg_data,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [pisp_pkg::MODE_W-1:0]       mode,
  input  logic [pisp_pkg::SLOT_W-1:0]       entry_index,
  input  logic [pisp_pkg::COLOR_W-1:0]      color_word,
  input  logic                              color_used,
  input  logic                              hole_flag,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [pisp_pkg::STATUS_W-1:0]     status,
  output logic [pisp_pkg::SLOT_W-1:0]       slot,
  output logic [pisp_pkg::COUNT_W-1:0]      new_count,
  output logic [pisp_pkg::TOTAL_W-1:0]      matched_total,
  output logic [pisp_pkg::TOTAL_W-1:0]      unmatched_total
);

  localparam int IW = $clog2(TABLE_ENTRIES);
  localparam logic [pisp_pkg::COUNT_W-1:0] TE9 = pisp_pkg::COUNT_W'(TABLE_ENTRIES);
  localparam logic [IW-1:0] LAST = IW'(TABLE_ENTRIES - 1);

  typedef enum logic [2:0] {IDLE, DISPATCH, SCAN, HOLE, FIN} state_t;

  state_t                              state;
  logic [pisp_pkg::MODE_W-1:0]         item_mode;
  logic [pisp_pkg::SLOT_W-1:0]         item_idx;
  logic [WORD_BITS-1:0]                key;
  logic                                item_used;
  logic                                item_hole;
  logic [IW-1:0]                       pos;
  logic [pisp_pkg::COUNT_W-1:0]        append_ptr;
  logic [pisp_pkg::COUNT_W-1:0]        hole_ptr;
  logic [pisp_pkg::COUNT_W-1:0]        size_so_far;
  logic [pisp_pkg::TOTAL_W-1:0]        match_count;
  logic [pisp_pkg::TOTAL_W-1:0]        miss_count;
  logic [pisp_pkg::COUNT_W-1:0]        dest_count;
  logic [pisp_pkg::COUNT_W-1:0]        dest_capacity;
  logic [pisp_pkg::STATUS_W-1:0]       res_status;
  logic [pisp_pkg::SLOT_W-1:0]         res_slot;

  logic [pisp_pkg::COUNT_W-1:0]        n_taken;
  logic [pisp_pkg::COUNT_W-1:0]        cap_lim;
  logic [pisp_pkg::COUNT_W-1:0]        cap_taken;
  logic [pisp_pkg::COUNT_W-1:0]        idx9;
  pisp_pkg::cell_cmd_t                 cmd;
  logic [IW-1:0]                       sel_idx;
  logic                                start;
  logic                                hit_any;
  logic                                hole_here;
  logic [TABLE_ENTRIES-1:0]            tok_out;
  logic [TABLE_ENTRIES-1:0]            hit;
  logic [TABLE_ENTRIES-1:0]            reus_vec;

  assign n_taken   = (dest_count > TE9) ? TE9 : dest_count;
  assign cap_lim   = (dest_capacity > TE9) ? TE9 : dest_capacity;
  assign cap_taken = (cap_lim < n_taken) ? n_taken : cap_lim;
  assign idx9      = {1'b0, item_idx};
  assign hit_any   = |hit;
  assign hole_here = (hole_ptr < n_taken) && reus_vec[hole_ptr[IW-1:0]];
  assign in_ready  = (state == IDLE);
  assign cfg_ready = 1'b1;

  genvar j;
  generate
    for (j = 0; j < TABLE_ENTRIES; j++) begin : g_cell
      logic tin;
      if (j == 0) begin : g_first
        assign tin = 1'b0;
      end else if (j == 1) begin : g_start
        assign tin = start;
      end else begin : g_chain
        assign tin = tok_out[j-1];
      end
      pisp_cell #(.WORD_BITS(WORD_BITS)) u_cell (
        .clk      (clk),
        .rst      (rst),
        .cmd      (cmd),
        .sel      (sel_idx == IW'(j)),
        .wr_data  (key),
        .key      (key),
        .tok_in   (tin),
        .tok_out  (tok_out[j]),
        .hit      (hit[j]),
        .reusable (reus_vec[j])
      );
    end
  endgenerate

  always_comb begin
    cmd     = '0;
    sel_idx = item_idx[IW-1:0];
    start   = 1'b0;
    case (state)
      DISPATCH: begin
        case (item_mode)
          pisp_pkg::MODE_BEGIN: cmd.clr = 1'b1;
          pisp_pkg::MODE_LOAD: begin
            if (idx9 < TE9) begin
              cmd.wr_word = 1'b1;
              if (idx9 < n_taken) begin
                cmd.set_occ = 1'b1;
                if (item_idx != '0) begin
                  cmd.wr_reus  = 1'b1;
                  cmd.reus_val = item_hole;
                end
              end
            end
          end
          pisp_pkg::MODE_IMPORT: start = item_used && (item_idx != '0);
          default: ;
        endcase
      end
      SCAN: begin
        if (hit_any) begin
          sel_idx     = pos;
          cmd.wr_reus = 1'b1;
        end else if (pos == LAST && append_ptr < cap_taken) begin
          sel_idx     = append_ptr[IW-1:0];
          cmd.wr_word = 1'b1;
          cmd.set_occ = 1'b1;
          cmd.wr_reus = 1'b1;
        end
      end
      HOLE: begin
        if (hole_here) begin
          sel_idx     = hole_ptr[IW-1:0];
          cmd.wr_word = 1'b1;
          cmd.set_occ = 1'b1;
          cmd.wr_reus = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= IDLE;
      append_ptr    <= '0;
      hole_ptr      <= pisp_pkg::COUNT_W'(1);
      size_so_far   <= '0;
      match_count   <= '0;
      miss_count    <= '0;
      dest_count    <= '0;
      dest_capacity <= pisp_pkg::COUNT_W'(256);
      out_valid     <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == pisp_pkg::CFG_DEST_COUNT) dest_count <= cfg_data;
        else dest_capacity <= cfg_data;
      end
      if (out_valid && out_ready && state != FIN) out_valid <= 1'b0;
      unique case (state)
        IDLE: begin
          if (in_valid) begin
            item_mode <= mode;
            item_idx  <= entry_index;
            key       <= WORD_BITS'(color_word);
            item_used <= color_used;
            item_hole <= hole_flag;
            state     <= DISPATCH;
          end
        end
        DISPATCH: begin
          res_status <= pisp_pkg::ST_DONE;
          res_slot   <= '0;
          state      <= FIN;
          if (item_mode == pisp_pkg::MODE_BEGIN) begin
            append_ptr  <= n_taken;
            hole_ptr    <= pisp_pkg::COUNT_W'(1);
            size_so_far <= n_taken;
            match_count <= '0;
            miss_count  <= '0;
          end else if (item_mode == pisp_pkg::MODE_IMPORT) begin
            if (start) begin
              pos   <= IW'(1);
              state <= SCAN;
            end else begin
              res_status <= pisp_pkg::ST_SKIP;
            end
          end
        end
        SCAN: begin
          if (hit_any) begin
            if (match_count != pisp_pkg::TOTAL_MAX) match_count <= match_count + 1'b1;
            res_status <= pisp_pkg::ST_MATCH;
            res_slot   <= pisp_pkg::SLOT_W'(pos);
            state      <= FIN;
          end else if (pos == LAST) begin
            if (append_ptr < cap_taken) begin
              append_ptr <= append_ptr + 1'b1;
              if (append_ptr + 1'b1 > size_so_far) size_so_far <= append_ptr + 1'b1;
              res_status <= pisp_pkg::ST_ADD;
              res_slot   <= append_ptr[pisp_pkg::SLOT_W-1:0];
              state      <= FIN;
            end else begin
              state <= HOLE;
            end
          end else begin
            pos <= pos + 1'b1;
          end
        end
        HOLE: begin
          if (hole_ptr < n_taken) begin
            hole_ptr <= hole_ptr + 1'b1;
            if (hole_here) begin
              if (hole_ptr + 1'b1 > size_so_far) size_so_far <= hole_ptr + 1'b1;
              res_status <= pisp_pkg::ST_ADD;
              res_slot   <= hole_ptr[pisp_pkg::SLOT_W-1:0];
              state      <= FIN;
            end
          end else begin
            if (miss_count != pisp_pkg::TOTAL_MAX) miss_count <= miss_count + 1'b1;
            res_status <= pisp_pkg::ST_NOROOM;
            res_slot   <= '0;
            state      <= FIN;
          end
        end
        FIN: begin
          if (!out_valid || out_ready) begin
            status          <= res_status;
            slot            <= res_slot;
            new_count       <= size_so_far;
            matched_total   <= match_count;
            unmatched_total <= miss_count;
            out_valid       <= 1'b1;
            state           <= IDLE;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

endmodule

// ===== src/pisp_cell.sv =====
// ----------------------------------------------------------------------------
// pisp_cell
// One ledger slot: color word, occupied and hole bits, and a search token
// that moves on to the next slot when this one does not match.
// ----------------------------------------------------------------------------
module pisp_cell #(
  parameter int WORD_BITS = 16
) (
  input  logic                   clk,
  input  logic                   rst,
  input  pisp_pkg::cell_cmd_t    cmd,
  input  logic                   sel,
  input  logic [WORD_BITS-1:0]   wr_data,
  input  logic [WORD_BITS-1:0]   key,
  input  logic                   tok_in,
  output logic                   tok_out,
  output logic                   hit,
  output logic                   reusable
);

  logic [WORD_BITS-1:0] word;
  logic                 occ;
  logic                 reus;
  logic                 tok;
  logic                 match;

  assign match    = occ && (word == key);
  assign hit      = tok && match;
  assign tok_out  = tok && !match;
  assign reusable = reus;

  always_ff @(posedge clk) begin
    if (rst) begin
      occ  <= 1'b0;
      reus <= 1'b0;
      tok  <= 1'b0;
    end else begin
      tok <= tok_in;
      if (cmd.clr) begin
        occ  <= 1'b0;
        reus <= 1'b0;
      end else if (sel) begin
        if (cmd.set_occ) occ <= 1'b1;
        if (cmd.wr_reus) reus <= cmd.reus_val;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (sel && cmd.wr_word) word <= wr_data;
  end

endmodule

// ===== src/pisp_checker.sv =====
// ----------------------------------------------------------------------------
// pisp_checker
// Port-level checks of the palette import slot planner.
// ----------------------------------------------------------------------------
module pisp_checker (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_ready,
  input logic [2:0] status,
  input logic [7:0] slot,
  input logic [8:0] new_count
);

  a_status_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (status <= pisp_pkg::ST_NOROOM))
    else $error("status out of range");

  a_slot_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != pisp_pkg::ST_MATCH && status != pisp_pkg::ST_ADD
      |-> slot == '0)
    else $error("slot nonzero without match or add");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (new_count <= 9'd256))
    else $error("new_count beyond table");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(status) && $stable(slot))
    else $error("result changed while stalled");

endmodule

bind palette_import_slot_planner pisp_checker u_pisp_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .status    (status),
  .slot      (slot),
  .new_count (new_count)
);
